// ===== sv/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg : shared types and constants of the threshold cascade block
// field widths, item mode codes and the per-node memory word
// ----------------------------------------------------------------------------
package tcg_pkg;

   localparam int MODE_W  = 3;
   localparam int ID_W    = 8;
   localparam int COUNT_W = 8;
   localparam int TOTAL_W = 9;
   localparam int WORD_W  = 64;

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SEED  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_EDGE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RUN   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;

   // one entry of the node memory
   typedef struct packed {
      logic               famous;
      logic [COUNT_W-1:0] count;
   } node_word_type;

endpackage

// ===== sv/tcg_req_if.sv =====
// ----------------------------------------------------------------------------
// tcg_req_if : request channel
// valid/ready handshake carrying one command item
// ----------------------------------------------------------------------------
interface tcg_req_if;
   logic                         valid;
   logic                         ready;
   logic [tcg_pkg::MODE_W-1:0]   mode;
   logic [tcg_pkg::ID_W-1:0]     node_a;
   logic [tcg_pkg::ID_W-1:0]     node_b;

   modport source (output valid, output mode, output node_a, output node_b, input ready);
   modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

// ===== sv/tcg_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcg_rsp_if : response channel
// valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface tcg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic                          is_famous;
   logic [tcg_pkg::TOTAL_W-1:0]   famous_total;

   modport source (output valid, output status, output is_famous, output famous_total,
                   input ready);
   modport sink   (input valid, input status, input is_famous, input famous_total,
                   output ready);
endinterface

// ===== sv/tcg_ram.sv =====
// ----------------------------------------------------------------------------
// tcg_ram : simple dual-port synchronous memory
// one write port, one read port, registered read data held between reads
// ----------------------------------------------------------------------------
module tcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/threshold_cascade_graph.sv =====
// ----------------------------------------------------------------------------
// threshold_cascade_graph : threshold cascade over an undirected graph
// clears, seeds, edges, breadth-first spread and flag queries on numbered nodes
// ----------------------------------------------------------------------------
// Commands arrive on req_chan (mode, node_a, node_b) and every command gives
// exactly one result on rsp_chan (status, is_famous, famous_total). csr_we
// with csr_wdata writes the threshold; write it only while the block idles.
// The block works on one command at a time. Seed and query read the node
// word and then check it. An edge reads and tests one adjacency word, sets
// the bit if it was clear and then reads and sets the mirror word; an
// immediate reject goes straight to the response state. A clear sweeps the
// adjacency memory one word a cycle and zeroes the node memory and the
// famous total. A run sweeps the node memory, then for every node taken
// from the work queue scans its adjacency row of ROW_WORDS = ceil(NODES/64)
// words one bit a cycle, with one node memory read per neighbour. After
// reset the same clearing pass runs and req_chan is not ready until it
// ends; no result is given for it.
// A finished result sits in an output register; a new command is taken
// while it waits, but that command's result waits until rsp_chan is free.
// ----------------------------------------------------------------------------
module threshold_cascade_graph #(
   parameter int NODE_COUNT = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   tcg_req_if.sink                   req_chan,
   tcg_rsp_if.source                 rsp_chan,
   input  logic                      csr_we,
   input  logic [tcg_pkg::COUNT_W-1:0] csr_wdata
);

   localparam int NODES     = (NODE_COUNT < 256) ? NODE_COUNT : 256;
   localparam int IB        = $clog2(NODES);
   localparam int CW        = $clog2(NODES + 1);
   localparam int ROW_WORDS = (NODES + 63) / 64;
   localparam int ADJ_DEPTH = NODES * 4;
   localparam int AW        = $clog2(ADJ_DEPTH);
   localparam int NODE_W    = $bits(tcg_pkg::node_word_type);

   localparam logic [CW-1:0] NODES_C    = CW'(NODES);
   localparam logic [AW-1:0] NODES_A    = AW'(NODES);
   localparam logic [AW-1:0] ADJ_LAST   = AW'(ADJ_DEPTH - 1);
   localparam logic [8:0]    NODES_9    = 9'(NODES);
   localparam logic [1:0]    LAST_WORD  = 2'(ROW_WORDS - 1);

   typedef enum logic [16:0] {
      ST_IDLE     = 17'b00000000000000001,
      ST_CLEAR    = 17'b00000000000000010,
      ST_SEED_RD  = 17'b00000000000000100,
      ST_SEED_CHK = 17'b00000000000001000,
      ST_QRY_RD   = 17'b00000000000010000,
      ST_QRY_CHK  = 17'b00000000000100000,
      ST_EDGE_RD1 = 17'b00000000001000000,
      ST_EDGE_CHK = 17'b00000000010000000,
      ST_EDGE_RD2 = 17'b00000000100000000,
      ST_EDGE_WR2 = 17'b00000001000000000,
      ST_PREP     = 17'b00000010000000000,
      ST_POP      = 17'b00000100000000000,
      ST_LOAD     = 17'b00001000000000000,
      ST_SCAN_RD  = 17'b00010000000000000,
      ST_SCAN     = 17'b00100000000000000,
      ST_DRAIN    = 17'b01000000000000000,
      ST_RESP     = 17'b10000000000000000
   } state_type;

   state_type state_ff, state_in;
   logic                         boot_ff, boot_in;
   logic [tcg_pkg::COUNT_W-1:0]  thr_ff, thr_in;
   logic [tcg_pkg::ID_W-1:0]     a_ff, a_in;
   logic [tcg_pkg::ID_W-1:0]     b_ff, b_in;
   logic [AW-1:0]                clr_ptr_ff, clr_ptr_in;
   logic [CW-1:0]                sp_ff, sp_in;
   logic [CW-1:0]                head_ff, head_in;
   logic [CW-1:0]                tail_ff, tail_in;
   logic [tcg_pkg::TOTAL_W-1:0]  cnt_ff, cnt_in;
   logic [IB-1:0]                cur_ff, cur_in;
   logic [1:0]                   w_ff, w_in;
   logic [5:0]                   bit_ff, bit_in;
   logic                         nv_ff, nv_in;
   logic [IB-1:0]                na_ff, na_in;
   logic                         nk_ff, nk_in;
   logic                         res_status_ff, res_status_in;
   logic                         res_fam_ff, res_fam_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic                         rsp_fam_ff, rsp_fam_in;
   logic [tcg_pkg::TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   // memory ports
   logic                         adj_we, adj_re;
   logic [AW-1:0]                adj_waddr, adj_raddr;
   logic [tcg_pkg::WORD_W-1:0]   adj_wdata, adj_rdata;
   logic                         node_we, node_re;
   logic [IB-1:0]                node_waddr, node_raddr;
   tcg_pkg::node_word_type       node_wdata, node_rdata;
   logic                         q_we, q_re;
   logic [IB-1:0]                q_waddr, q_raddr, q_wdata, q_rdata;

   // scratch
   logic [tcg_pkg::COUNT_W-1:0]  thr_eff;
   logic [tcg_pkg::COUNT_W-1:0]  inc_count;
   logic                         inc_famous;
   logic [9:0]                   adj_addr10;
   logic [7:0]                   scan_v;
   logic                         a_ok, b_ok;

   tcg_ram #(.WIDTH(tcg_pkg::WORD_W), .DEPTH(ADJ_DEPTH)) u_adj (
      .clock (clock), .we (adj_we), .waddr (adj_waddr), .wdata (adj_wdata),
      .re (adj_re), .raddr (adj_raddr), .rdata (adj_rdata)
   );

   tcg_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node (
      .clock (clock), .we (node_we), .waddr (node_waddr), .wdata (node_wdata),
      .re (node_re), .raddr (node_raddr), .rdata (node_rdata)
   );

   tcg_ram #(.WIDTH(IB), .DEPTH(NODES)) u_queue (
      .clock (clock), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
      .re (q_re), .raddr (q_raddr), .rdata (q_rdata)
   );

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.is_famous     = rsp_fam_ff;
   assign rsp_chan.famous_total  = rsp_total_ff;

   // a threshold of zero behaves as one
   assign thr_eff    = (thr_ff == '0) ? 8'd1 : thr_ff;
   assign inc_count  = (node_rdata.count == 8'hFF) ? node_rdata.count
                                                   : node_rdata.count + 8'd1;
   assign inc_famous = (inc_count >= thr_eff);
   assign scan_v     = {w_ff, bit_ff};
   assign a_ok       = ({1'b0, req_chan.node_a} < NODES_9);
   assign b_ok       = ({1'b0, req_chan.node_b} < NODES_9);

   // sequencer and read-modify-write datapath
   always_comb begin
      state_in      = state_ff;
      boot_in       = boot_ff;
      thr_in        = csr_we ? csr_wdata : thr_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      clr_ptr_in    = clr_ptr_ff;
      sp_in         = sp_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      w_in          = w_ff;
      bit_in        = bit_ff;
      nv_in         = 1'b0;
      na_in         = na_ff;
      nk_in         = nk_ff;
      res_status_in = res_status_ff;
      res_fam_in    = res_fam_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_fam_in    = rsp_fam_ff;
      rsp_total_in  = rsp_total_ff;
      adj_we        = 1'b0;
      adj_re        = 1'b0;
      adj_waddr     = '0;
      adj_raddr     = '0;
      adj_wdata     = '0;
      node_we       = 1'b0;
      node_re       = 1'b0;
      node_waddr    = '0;
      node_raddr    = '0;
      node_wdata    = '0;
      q_we          = 1'b0;
      q_re          = 1'b0;
      q_waddr       = tail_ff[IB-1:0];
      q_raddr       = head_ff[IB-1:0];
      q_wdata       = na_ff;
      adj_addr10    = '0;

      // node update stage: count a neighbour, or reset a count during prep
      if (nv_ff) begin
         node_we    = 1'b1;
         node_waddr = na_ff;
         if (nk_ff) begin
            if (node_rdata.famous) begin
               node_wdata = node_rdata;
            end else begin
               node_wdata.famous = inc_famous;
               node_wdata.count  = inc_count;
               if (inc_famous) begin
                  cnt_in = cnt_ff + 9'd1;
                  if (tail_ff < NODES_C) begin
                     q_we    = 1'b1;
                     tail_in = tail_ff + CW'(1);
                  end
               end
            end
         end else begin
            node_wdata.famous = node_rdata.famous;
            node_wdata.count  = '0;
            if (node_rdata.famous && (tail_ff < NODES_C)) begin
               q_we    = 1'b1;
               tail_in = tail_ff + CW'(1);
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               a_in          = req_chan.node_a;
               b_in          = req_chan.node_b;
               res_status_in = 1'b0;
               res_fam_in    = 1'b0;
               case (req_chan.mode)
                  tcg_pkg::MODE_CLEAR: begin
                     clr_ptr_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  tcg_pkg::MODE_SEED: begin
                     if (a_ok) begin
                        state_in = ST_SEED_RD;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  tcg_pkg::MODE_EDGE: begin
                     if (a_ok && b_ok && (req_chan.node_a != req_chan.node_b)) begin
                        state_in = ST_EDGE_RD1;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  tcg_pkg::MODE_RUN: begin
                     sp_in    = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = ST_PREP;
                  end
                  tcg_pkg::MODE_QUERY: begin
                     if (a_ok) begin
                        state_in = ST_QRY_RD;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  default: begin
                     res_status_in = 1'b1;
                     state_in      = ST_RESP;
                  end
               endcase
            end
         end
         // clearing pass over both memories
         ST_CLEAR: begin
            adj_we    = 1'b1;
            adj_waddr = clr_ptr_ff;
            if (clr_ptr_ff < NODES_A) begin
               node_we    = 1'b1;
               node_waddr = clr_ptr_ff[IB-1:0];
            end
            cnt_in     = '0;
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == ADJ_LAST) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? ST_IDLE : ST_RESP;
            end
         end
         ST_SEED_RD: begin
            node_re    = 1'b1;
            node_raddr = a_ff[IB-1:0];
            state_in   = ST_SEED_CHK;
         end
         ST_SEED_CHK: begin
            if (node_rdata.famous) begin
               res_status_in = 1'b1;
            end else begin
               node_we           = 1'b1;
               node_waddr        = a_ff[IB-1:0];
               node_wdata.famous = 1'b1;
               node_wdata.count  = node_rdata.count;
               cnt_in            = cnt_ff + 9'd1;
            end
            state_in = ST_RESP;
         end
         ST_QRY_RD: begin
            node_re    = 1'b1;
            node_raddr = a_ff[IB-1:0];
            state_in   = ST_QRY_CHK;
         end
         ST_QRY_CHK: begin
            res_fam_in = node_rdata.famous;
            state_in   = ST_RESP;
         end
         // edge insert: test one direction, then set both
         ST_EDGE_RD1: begin
            adj_addr10 = {a_ff, b_ff[7:6]};
            adj_re     = 1'b1;
            adj_raddr  = adj_addr10[AW-1:0];
            state_in   = ST_EDGE_CHK;
         end
         ST_EDGE_CHK: begin
            adj_addr10 = {a_ff, b_ff[7:6]};
            if (adj_rdata[b_ff[5:0]]) begin
               res_status_in = 1'b1;
               state_in      = ST_RESP;
            end else begin
               adj_we    = 1'b1;
               adj_waddr = adj_addr10[AW-1:0];
               adj_wdata = adj_rdata | (64'd1 << b_ff[5:0]);
               state_in  = ST_EDGE_RD2;
            end
         end
         ST_EDGE_RD2: begin
            adj_addr10 = {b_ff, a_ff[7:6]};
            adj_re     = 1'b1;
            adj_raddr  = adj_addr10[AW-1:0];
            state_in   = ST_EDGE_WR2;
         end
         ST_EDGE_WR2: begin
            adj_addr10 = {b_ff, a_ff[7:6]};
            adj_we     = 1'b1;
            adj_waddr  = adj_addr10[AW-1:0];
            adj_wdata  = adj_rdata | (64'd1 << a_ff[5:0]);
            state_in   = ST_RESP;
         end
         // run prep: zero counts, queue famous nodes in id order
         ST_PREP: begin
            if (sp_ff < NODES_C) begin
               node_re    = 1'b1;
               node_raddr = sp_ff[IB-1:0];
               nv_in      = 1'b1;
               na_in      = sp_ff[IB-1:0];
               nk_in      = 1'b0;
               sp_in      = sp_ff + CW'(1);
            end else if (!nv_ff) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (head_ff < tail_ff) begin
               q_re     = 1'b1;
               head_in  = head_ff + CW'(1);
               state_in = ST_LOAD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LOAD: begin
            cur_in   = q_rdata;
            w_in     = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            adj_addr10 = {8'(cur_ff), w_ff};
            adj_re     = 1'b1;
            adj_raddr  = adj_addr10[AW-1:0];
            bit_in     = '0;
            state_in   = ST_SCAN;
         end
         // one adjacency bit a cycle, neighbours go to the update stage
         ST_SCAN: begin
            if (adj_rdata[bit_ff] && ({1'b0, scan_v} < NODES_9)) begin
               node_re    = 1'b1;
               node_raddr = scan_v[IB-1:0];
               nv_in      = 1'b1;
               na_in      = scan_v[IB-1:0];
               nk_in      = 1'b1;
            end
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd63) begin
               if (w_ff == LAST_WORD) begin
                  state_in = ST_DRAIN;
               end else begin
                  w_in     = w_ff + 2'd1;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_POP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_fam_in    = res_fam_ff;
               rsp_total_in  = cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         thr_ff       <= 8'd1;
         clr_ptr_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         nv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         thr_ff       <= thr_in;
         clr_ptr_ff   <= clr_ptr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cnt_ff       <= cnt_in;
         nv_ff        <= nv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      sp_ff         <= sp_in;
      cur_ff        <= cur_in;
      w_ff          <= w_in;
      bit_ff        <= bit_in;
      na_ff         <= na_in;
      nk_ff         <= nk_in;
      res_status_ff <= res_status_in;
      res_fam_ff    <= res_fam_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fam_ff    <= rsp_fam_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

// ===== tb/tcg_tb_if.sv =====
// ----------------------------------------------------------------------------
// tcg_tb_if : testbench package tcg_tb_pkg with the command and result item types
// the request and response interfaces come from the design sources
// ----------------------------------------------------------------------------
package tcg_tb_pkg;

   timeunit 1ns;
   timeprecision 1ps;

   // one command item as the testbench holds it
   typedef struct packed {
      logic [tcg_pkg::MODE_W-1:0] mode;
      logic [tcg_pkg::ID_W-1:0]   node_a;
      logic [tcg_pkg::ID_W-1:0]   node_b;
      logic                       cfg_write;
      logic [tcg_pkg::COUNT_W-1:0] cfg_value;
   } command_type;

   // one result item
   typedef struct packed {
      logic                        status;
      logic                        is_famous;
      logic [tcg_pkg::TOTAL_W-1:0] famous_total;
   } outcome_type;

endpackage

// ===== tb/tb_threshold_cascade_graph.sv =====
// ----------------------------------------------------------------------------
// tb_threshold_cascade_graph : self-checking bench for the threshold cascade
// drives seeds, edges, runs, queries and clears, predicts every result with
// a behavioural graph model and compares each result transfer field by field
// ----------------------------------------------------------------------------
module tb_threshold_cascade_graph;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES     = 256;
   localparam int NUM_RAND  = 1400;
   localparam int MAX_CYC   = 40000000;
   localparam int SETTLE    = 2000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [tcg_pkg::COUNT_W-1:0] csr_wdata;

   tcg_req_if req_chan ();
   tcg_rsp_if rsp_chan ();

   threshold_cascade_graph #(.NODE_COUNT(NODES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // graph model state
   bit          adj [NODES][NODES];
   bit          famous [NODES];
   int unsigned contacts [NODES];
   int unsigned famous_cnt;
   int unsigned thresh;

   tcg_tb_pkg::command_type pending_cmds [$];
   tcg_tb_pkg::outcome_type expected_outcomes [$];
   int          mismatches;
   int          cycle_cnt;
   bit          stim_done;
   bit          calm;        // no idling in the last part of the run
   int          req_gap;
   int          rsp_stall;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void model_clear();
      foreach (adj[i, j]) adj[i][j] = 1'b0;
      foreach (famous[i]) begin
         famous[i]   = 1'b0;
         contacts[i] = 0;
      end
      famous_cnt = 0;
   endfunction

   // breadth-first spread from every famous node
   function automatic void model_spread();
      int q [$];
      int cur;
      int eff;
      eff = (thresh == 0) ? 1 : thresh;
      foreach (contacts[i]) contacts[i] = 0;
      for (int v = 0; v < NODES; v++) if (famous[v]) q.insert(q.size(), v);
      while (q.size() > 0) begin
         cur = q.pop_front();
         for (int v = 0; v < NODES; v++) begin
            if (adj[cur][v] && !famous[v]) begin
               if (contacts[v] < 255) contacts[v]++;
               if (contacts[v] >= eff) begin
                  famous[v] = 1'b1;
                  famous_cnt++;
                  q.insert(q.size(), v);
               end
            end
         end
      end
   endfunction

   // expected result of one accepted command
   function automatic tcg_tb_pkg::outcome_type predict_outcome(tcg_tb_pkg::command_type c);
      tcg_tb_pkg::outcome_type o;
      o = '0;
      case (c.mode)
         tcg_pkg::MODE_CLEAR: model_clear();
         tcg_pkg::MODE_SEED: begin
            if (famous[c.node_a]) o.status = 1'b1;
            else begin
               famous[c.node_a] = 1'b1;
               famous_cnt++;
            end
         end
         tcg_pkg::MODE_EDGE: begin
            if (c.node_a == c.node_b || adj[c.node_a][c.node_b]) o.status = 1'b1;
            else begin
               adj[c.node_a][c.node_b] = 1'b1;
               adj[c.node_b][c.node_a] = 1'b1;
            end
         end
         tcg_pkg::MODE_RUN: model_spread();
         tcg_pkg::MODE_QUERY: o.is_famous = famous[c.node_a];
         default: o.status = 1'b1;
      endcase
      o.famous_total = (famous_cnt > 511) ? 9'd511 : famous_cnt[tcg_pkg::TOTAL_W-1:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_cnt);
      mismatches++;
   endtask

   function automatic tcg_tb_pkg::command_type make_cmd(int m, int a, int b);
      tcg_tb_pkg::command_type c;
      c = '0;
      c.mode   = m[tcg_pkg::MODE_W-1:0];
      c.node_a = a[tcg_pkg::ID_W-1:0];
      c.node_b = b[tcg_pkg::ID_W-1:0];
      return c;
   endfunction

   function automatic tcg_tb_pkg::command_type make_cfg(int value);
      tcg_tb_pkg::command_type c;
      c = '0;
      c.cfg_write = 1'b1;
      c.cfg_value = value[tcg_pkg::COUNT_W-1:0];
      return c;
   endfunction

   // append one item to the pending list
   function automatic void add_cmd(tcg_tb_pkg::command_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   // a small graph with random content, then a run and queries
   task automatic queue_random_graph(int span);
      int n;
      int base;
      base = $urandom_range(0, NODES - span);
      n = $urandom_range(4, 20);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1: add_cmd(make_cmd(tcg_pkg::MODE_SEED,
                     base + $urandom_range(0, span - 1), $urandom));
            9: add_cmd(make_cmd($urandom_range(0, 7), $urandom, $urandom));
            default: add_cmd(make_cmd(tcg_pkg::MODE_EDGE,
                     base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1)));
         endcase
      end
      add_cmd(make_cmd(tcg_pkg::MODE_RUN, $urandom, $urandom));
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         add_cmd(make_cmd(tcg_pkg::MODE_QUERY, base + $urandom_range(0, span - 1),
                          $urandom));
   endtask

   // stimulus
   initial begin
      int thr_list [6];
      thr_list = '{1, 2, 3, 255, 0, 1};
      reset = 1'b1;
      stim_done = 1'b0;
      calm = 1'b0;
      mismatches = 0;
      thresh = 1;
      model_clear();
      // directed: extremes, every mode, special cases
      add_cmd(make_cmd(tcg_pkg::MODE_QUERY, 0, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_SEED, 0, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_SEED, 0, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_SEED, 255, 255));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 0, 255));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 255, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 7, 7));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 0, 1));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 1, 2));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 170, 85));
      add_cmd(make_cmd(tcg_pkg::MODE_RUN, 0, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_QUERY, 2, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_QUERY, 255, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_EDGE, 2, 85));
      add_cmd(make_cmd(tcg_pkg::MODE_RUN, 0, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_QUERY, 170, 0));
      add_cmd(make_cmd(5, 255, 255));
      add_cmd(make_cmd(6, 0, 0));
      add_cmd(make_cmd(7, 170, 85));
      add_cmd(make_cmd(tcg_pkg::MODE_CLEAR, 0, 0));
      add_cmd(make_cmd(tcg_pkg::MODE_QUERY, 0, 0));
      // phases at several thresholds, each starting from a clear
      for (int p = 0; p < 6; p++) begin
         add_cmd(make_cfg(thr_list[p]));
         add_cmd(make_cmd(tcg_pkg::MODE_CLEAR, $urandom, $urandom));
         while (pending_cmds.size() < (NUM_RAND * (p + 1)) / 6)
            queue_random_graph((p == 3) ? 8 : 16);
         // long run over a wider graph once per phase
         queue_random_graph(NODES);
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
   end

   // driver: one transfer per handshake, config writes only when idle
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.mode <= '0;
         req_chan.node_a <= '0;
         req_chan.node_b <= '0;
         csr_we <= 1'b0;
         csr_wdata <= '0;
         req_gap <= 0;
      end else begin
         csr_we <= 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            expected_outcomes.insert(expected_outcomes.size(),
                                     predict_outcome(pending_cmds.pop_front()));
            if (pending_cmds.size() < 60) calm = 1'b1;
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (pending_cmds.size() == 0) begin
               req_chan.valid <= 1'b0;
               stim_done = 1'b1;
            end else if (pending_cmds[0].cfg_write) begin
               // hold off until all results are back, then settle and write
               req_chan.valid <= 1'b0;
               if (expected_outcomes.size() == 0) begin
                  if (req_gap < SETTLE) req_gap <= req_gap + 1;
                  else begin
                     csr_we <= 1'b1;
                     csr_wdata <= pending_cmds[0].cfg_value;
                     thresh = pending_cmds[0].cfg_value;
                     void'(pending_cmds.pop_front());
                     req_gap <= 0;
                  end
               end
            end else if (req_gap > 0) begin
               req_chan.valid <= 1'b0;
               req_gap <= req_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               req_chan.valid <= 1'b0;
               req_gap <= $urandom_range(0, 3);
            end else begin
               req_chan.valid <= 1'b1;
               req_chan.mode <= pending_cmds[0].mode;
               req_chan.node_a <= pending_cmds[0].node_a;
               req_chan.node_b <= pending_cmds[0].node_b;
            end
         end
      end
   end

   // monitor: compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      tcg_tb_pkg::outcome_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", rsp_chan.status, want.status);
               if (rsp_chan.is_famous !== want.is_famous)
                  report_mismatch("is_famous", rsp_chan.is_famous, want.is_famous);
               if (rsp_chan.famous_total !== want.famous_total)
                  report_mismatch("famous_total", rsp_chan.famous_total,
                                  want.famous_total);
            end
         end
         if (rsp_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall <= $urandom_range(0, 3);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // end of run and timeout
   initial begin
      cycle_cnt = 0;
      forever begin
         @(posedge clock);
         cycle_cnt++;
         if (cycle_cnt > MAX_CYC) begin
            $display("FAIL threshold_cascade_graph");
            $finish;
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_outcomes.size() == 0)
         $display("PASS threshold_cascade_graph");
      else
         $display("FAIL threshold_cascade_graph");
      $finish;
   end

endmodule
